// ----- sv/mecanum_wheel_odometry_defines.svh -----
// Assertion macros shared by the odometry block.
`ifndef MECANUM_WHEEL_ODOMETRY_DEFINES_SVH
`define MECANUM_WHEEL_ODOMETRY_DEFINES_SVH

// The antecedent holding in a cycle implies the consequent in the same cycle.
`define MWO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The antecedent holding in a cycle implies the consequent in the next cycle.
`define MWO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/mwo_pkg.sv -----
package mwo_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int IDX_W         = 5;
    localparam int DIV_STEPS     = 18;
    localparam int MAG_W         = 36;
    localparam int QDEPTH        = 2;
    localparam int QAW           = 1;

    localparam logic [23:0]        DYAW_SCALE  = 24'd10937044;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [6:0]         DIVISOR     = 7'd125;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [23:0] om;
        logic [15:0]        dt;
        logic               use_given;
        logic [31:0]        given;
        logic               clr;
    } t_job;

    // Arctangent of 2^-i as a binary angle.
    function automatic logic [31:0] atan_angle(input logic [IDX_W-1:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2F9;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    // One radix-4 digit of a division by 125: returns {digit, remainder}.
    function automatic logic [8:0] div_step(input logic [8:0] t);
        logic [1:0] d;
        logic [8:0] r;
        if (t >= 9'd375) begin
            d = 2'd3;
            r = t - 9'd375;
        end else if (t >= 9'd250) begin
            d = 2'd2;
            r = t - 9'd250;
        end else if (t >= {2'b00, DIVISOR}) begin
            d = 2'd1;
            r = t - {2'b00, DIVISOR};
        end else begin
            d = 2'd0;
            r = t;
        end
        return {d, r[6:0]};
    endfunction

endpackage

// ----- sv/mecanum_wheel_odometry.sv -----
// Channel   Direction  Handshake                     Contents
// s_axis    in         s_axis_tvalid/s_axis_tready   wheel speeds, interval, heading, flags
// m_axis    out        m_axis_tvalid/m_axis_tready   body velocity, pose
// cfg       in         i_cfg_we                      recip_track_sum
//
// A request holds the back end, which takes one at a time: pop, two multiplies, heading update,
// CORDIC_STAGES CORDIC iterations (the 18-step divider runs beside them), the
// pose products in S_PROD1 to S_PROD3 and the update, which waits for a free output register.
// Reset is synchronous and active low; it zeroes the pose and loads 256 into the register.
// A two-entry queue decouples front and back, and an output register holds a
// result while m_axis_tready is low.
module mecanum_wheel_odometry (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // fl[15:0], fr[31:16], rl[47:32], rr[63:48], interval_ms[79:64],
    // given_heading[111:80]
    input  logic [111:0] s_axis_tdata,
    // yaw_from_input[0], clear_pose[1]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // body_vx[15:0], body_vy[31:16], body_omega[55:32], pose_x[87:56],
    // pose_y[119:88], pose_heading[151:120]
    output logic [151:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata
);

    // The reciprocal of the half wheelbase plus half track, Q8.8.
    logic [15:0]   r_recip;

    logic          push, full, pop, nonempty;
    mwo_pkg::t_job job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip <= 16'd256;
        end else if (i_cfg_we) begin
            r_recip <= i_cfg_wdata;
        end
    end

    // The front registers a request and forms vx, vy and the saturated omega.
    mwo_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .i_recip (r_recip),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    mwo_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (job_in),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_job      (job_out)
    );

    // The back end integrates heading and position with the CORDIC.
    mwo_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_job      (job_out),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule

// ----- sv/mwo_front.sv -----
module mwo_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [111:0]        i_data,
    input  logic [1:0]          i_user,
    input  logic [15:0]         i_recip,
    output logic                o_push,
    output mwo_pkg::t_job       o_job,
    input  logic                i_full
);

    logic        r_valid;
    logic [111:0] r_data;
    logic [1:0]  r_user;

    logic signed [15:0] fl, fr, rl, rr;
    logic signed [17:0] sum_x, sum_y, sum_w;
    logic signed [34:0] om_prod;
    logic signed [28:0] om_shift;

    assign fl = $signed(r_data[15:0]);
    assign fr = $signed(r_data[31:16]);
    assign rl = $signed(r_data[47:32]);
    assign rr = $signed(r_data[63:48]);

    always_comb begin
        sum_x    = 18'(fl) + 18'(fr) + 18'(rl) + 18'(rr);
        sum_y    = -18'(fl) + 18'(fr) + 18'(rl) - 18'(rr);
        sum_w    = -18'(fl) + 18'(fr) - 18'(rl) + 18'(rr);
        om_prod  = 35'(sum_w) * $signed({19'd0, i_recip});
        om_shift = 29'(om_prod >>> 6);
        o_job.vx = sum_x[17:2];
        o_job.vy = sum_y[17:2];
        if (om_shift > 29'sd8388607) begin
            o_job.om = 24'sh7FFFFF;
        end else if (om_shift < -29'sd8388608) begin
            o_job.om = 24'sh800000;
        end else begin
            o_job.om = om_shift[23:0];
        end
        o_job.dt        = r_data[79:64];
        o_job.given     = r_data[111:80];
        o_job.use_given = r_user[0];
        o_job.clr       = r_user[1];
    end

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= i_data;
            r_user <= i_user;
        end
    end

endmodule

// ----- sv/mwo_queue.sv -----
module mwo_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mwo_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output mwo_pkg::t_job o_job
);

    mwo_pkg::t_job            r_mem [mwo_pkg::QDEPTH];
    logic [mwo_pkg::QAW-1:0]  r_wptr;
    logic [mwo_pkg::QAW-1:0]  r_rptr;
    logic [mwo_pkg::QAW:0]    r_count;

    assign o_full     = (r_count == (mwo_pkg::QAW + 1)'(mwo_pkg::QDEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_job      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ----- sv/mwo_back.sv -----
`include "mecanum_wheel_odometry_defines.svh"

module mwo_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_nonempty,
    input  mwo_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [151:0]  o_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_YAW, S_CORD, S_PROD1, S_PROD2, S_PROD3, S_UPD
    } t_state;

    t_state                    r_state;
    mwo_pkg::t_job             r_job;
    logic signed [47:0]        r_p;
    logic [47:0]               r_pl;
    logic [23:0]               r_ph;
    logic [31:0]               r_heading;
    logic signed [31:0]        r_pos_x, r_pos_y;
    logic signed [33:0]        r_cx, r_cy, r_cz;
    logic                      r_neg;
    logic [mwo_pkg::IDX_W-1:0] r_i;
    logic                      r_dbusy;
    logic [4:0]                r_dcnt;
    logic [mwo_pkg::MAG_W-1:0] r_mx, r_my, r_qx, r_qy;
    logic [6:0]                r_rx, r_ry;
    logic                      r_sgx, r_sgy;
    logic signed [65:0]        r_m1, r_m2;
    logic signed [36:0]        r_sx, r_sy;
    logic                      r_o_valid;
    logic [151:0]              r_o_data;

    logic signed [32:0] pvx, pvy;
    logic [32:0]        avx, avy;
    logic [47:0]        dyaw_full;
    logic [31:0]        h_new, ang;
    logic               h_neg;
    logic signed [33:0] xs, ys, at, cos_v, sin_v;
    logic signed [31:0] dx, dy;
    logic [8:0]         dstep_x, dstep_y;
    logic signed [37:0] nx, ny;
    logic signed [31:0] px_sat, py_sat;
    logic               out_free;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -38'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    always_comb begin
        pvx       = $signed(33'(r_job.vx)) * $signed({17'd0, r_job.dt});
        pvy       = $signed(33'(r_job.vy)) * $signed({17'd0, r_job.dt});
        avx       = pvx[32] ? 33'(-pvx) : 33'(pvx);
        avy       = pvy[32] ? 33'(-pvy) : 33'(pvy);
        dyaw_full = r_pl + {r_ph, 24'd0};
        if (r_job.clr) begin
            h_new = '0;
        end else if (r_job.use_given) begin
            h_new = r_job.given;
        end else begin
            h_new = r_heading + dyaw_full[47:16];
        end
        h_neg = (h_new + 32'h40000000) >> 31 != 32'd0;
        ang   = h_neg ? h_new + 32'h80000000 : h_new;
        xs    = r_cx >>> r_i;
        ys    = r_cy >>> r_i;
        at    = $signed({2'b00, mwo_pkg::atan_angle(r_i)});
        cos_v = r_neg ? -r_cx : r_cx;
        sin_v = r_neg ? -r_cy : r_cy;
        dx    = r_sgx ? -$signed(r_qx[31:0]) : $signed(r_qx[31:0]);
        dy    = r_sgy ? -$signed(r_qy[31:0]) : $signed(r_qy[31:0]);
        dstep_x = mwo_pkg::div_step({r_rx, r_mx[mwo_pkg::MAG_W-1 -: 2]});
        dstep_y = mwo_pkg::div_step({r_ry, r_my[mwo_pkg::MAG_W-1 -: 2]});
        nx     = 38'(r_pos_x) + 38'(r_sx);
        ny     = 38'(r_pos_y) + 38'(r_sy);
        px_sat = sat32(nx);
        py_sat = sat32(ny);
    end

    assign out_free = !r_o_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && i_nonempty;
    assign o_valid  = r_o_valid;
    assign o_data   = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_heading <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dbusy   <= 1'b0;
            r_dcnt    <= '0;
            r_i       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && r_state != S_UPD) begin
                r_o_valid <= 1'b0;
            end
            if (r_dbusy) begin
                r_rx   <= dstep_x[6:0];
                r_ry   <= dstep_y[6:0];
                r_qx   <= {r_qx[mwo_pkg::MAG_W-3:0], dstep_x[8:7]};
                r_qy   <= {r_qy[mwo_pkg::MAG_W-3:0], dstep_y[8:7]};
                r_mx   <= r_mx << 2;
                r_my   <= r_my << 2;
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == 5'(mwo_pkg::DIV_STEPS - 1)) begin
                    r_dbusy <= 1'b0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_nonempty) begin
                        r_job   <= i_job;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p     <= 48'($signed(41'(r_job.om) * $signed({25'd0, r_job.dt})));
                    r_mx    <= {avx[30:0], 5'd0};
                    r_my    <= {avy[30:0], 5'd0};
                    r_sgx   <= pvx[32];
                    r_sgy   <= pvy[32];
                    r_rx    <= '0;
                    r_ry    <= '0;
                    r_qx    <= '0;
                    r_qy    <= '0;
                    r_dcnt  <= '0;
                    r_dbusy <= 1'b1;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_pl    <= r_p[23:0] * mwo_pkg::DYAW_SCALE;
                    r_ph    <= 24'(r_p[47:24] * mwo_pkg::DYAW_SCALE);
                    r_state <= S_YAW;
                end
                S_YAW: begin
                    r_heading <= h_new;
                    r_neg     <= h_neg;
                    r_cx      <= mwo_pkg::CORDIC_GAIN;
                    r_cy      <= '0;
                    r_cz      <= 34'($signed(ang));
                    r_i       <= '0;
                    r_state   <= S_CORD;
                end
                S_CORD: begin
                    if (r_i < mwo_pkg::IDX_W'(mwo_pkg::CORDIC_STAGES)) begin
                        if (!r_cz[33]) begin
                            r_cx <= r_cx - ys;
                            r_cy <= r_cy + xs;
                            r_cz <= r_cz - at;
                        end else begin
                            r_cx <= r_cx + ys;
                            r_cy <= r_cy - xs;
                            r_cz <= r_cz + at;
                        end
                        r_i <= r_i + 1'b1;
                    end else if (!r_dbusy) begin
                        r_state <= S_PROD1;
                    end
                end
                S_PROD1: begin
                    r_m1    <= 66'(dx) * 66'(cos_v);
                    r_m2    <= 66'(dy) * 66'(sin_v);
                    r_state <= S_PROD2;
                end
                S_PROD2: begin
                    r_sx    <= 37'((67'(r_m1) - 67'(r_m2)) >>> 30);
                    r_m1    <= 66'(dx) * 66'(sin_v);
                    r_m2    <= 66'(dy) * 66'(cos_v);
                    r_state <= S_PROD3;
                end
                S_PROD3: begin
                    r_sy    <= 37'((67'(r_m1) + 67'(r_m2)) >>> 30);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        if (r_job.clr) begin
                            r_pos_x  <= '0;
                            r_pos_y  <= '0;
                            r_o_data <= {r_heading, 64'd0, r_job.om, r_job.vy, r_job.vx};
                        end else begin
                            r_pos_x  <= px_sat;
                            r_pos_y  <= py_sat;
                            r_o_data <= {r_heading, py_sat, px_sat,
                                         r_job.om, r_job.vy, r_job.vx};
                        end
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end else if (r_o_valid && i_ready) begin
                        r_o_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `MWO_ASSERT_NOW(a_stage_bound, i_clk, i_rst_n, 1'b1, r_i <= mwo_pkg::IDX_W'(mwo_pkg::CORDIC_STAGES))
    `MWO_ASSERT_NOW(a_div_done, i_clk, i_rst_n, r_state == S_PROD1 || r_state == S_UPD, !r_dbusy)
    `MWO_ASSERT_NEXT(a_result_out, i_clk, i_rst_n, r_state == S_UPD && out_free, r_o_valid)

endmodule

// ----- bench/mecanum_wheel_odometry_test.sv -----
`timescale 1ns / 100ps

module mecanum_wheel_odometry_test;

    // A full update request as the sender offers it.
    typedef struct {
        logic signed [15:0] fl;
        logic signed [15:0] fr;
        logic signed [15:0] rl;
        logic signed [15:0] rr;
        logic [15:0]        dt;
        logic               use_given;
        logic [31:0]        given;
        logic               clr;
    } odo_req_t;

    // One body velocity and pose report.
    typedef struct {
        logic [15:0] vx;
        logic [15:0] vy;
        logic [23:0] om;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] hd;
    } pose_rpt_t;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int N_RANDOM     = 1600;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [31:0] ATAN_TBL [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic         i_cfg_we;
    logic [15:0]  i_cfg_wdata;

    mecanum_wheel_odometry dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Requests waiting to be offered, and reports the predictor has produced
    // but the block has not yet delivered.
    odo_req_t  pending_reqs[$];
    pose_rpt_t expected_rpts[$];

    // The predictor's own copy of the register and the pose.
    logic [15:0]        model_recip;
    logic signed [63:0] model_x;
    logic signed [63:0] model_y;
    logic [31:0]        model_heading;

    // Idle percentages per side, changed by the stimulus phases.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_request;
    int          hold_left;
    int          fail_count;
    int          report_count;
    int          cycle_count;
    bit          offering;

    // The handshake is seen at the rising edge; the driver acts on it at the
    // following falling edge.
    bit          s_axis_tready_seen;

    // Arithmetic shift right on a signed 64-bit value rounds toward minus
    // infinity, which matches the block's fixed-point rounding.
    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic cordic_sincos(input logic [31:0] ang, output logic signed [63:0] c,
                                 output logic signed [63:0] s);
        logic signed [63:0] x, y, z, xs, ys;
        bit flip;
        x = 64'sd652032874;
        y = '0;
        flip = 1'b0;
        // Angles in the left half plane are turned by a half turn first.
        if (((ang + 32'h40000000) & 32'h80000000) != 0) begin
            ang = ang + 32'h80000000;
            flip = 1'b1;
        end
        z = $signed({{32{ang[31]}}, ang});
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - $signed({32'd0, ATAN_TBL[i]});
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + $signed({32'd0, ATAN_TBL[i]});
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Advance the pose by one request and return the report it should produce.
    task automatic predict_pose(input odo_req_t r, output pose_rpt_t p);
        logic signed [63:0] fl, fr, rl, rr, dt, vx, vy, om, dx, dy, dyaw, c, s;
        fl = r.fl;
        fr = r.fr;
        rl = r.rl;
        rr = r.rr;
        dt = {48'd0, r.dt};
        vx = (fl + fr + rl + rr) >>> 2;
        vy = (-fl + fr + rl - rr) >>> 2;
        om = ((-fl + fr - rl + rr) * $signed({48'd0, model_recip})) >>> 6;
        if (om > 64'sd8388607) om = 64'sd8388607;
        if (om < -64'sd8388608) om = -64'sd8388608;
        if (r.clr) begin
            model_x = '0;
            model_y = '0;
            model_heading = '0;
        end else begin
            // Division truncates toward zero here, as required.
            dx = vx * dt * 256 / 1000;
            dy = vy * dt * 256 / 1000;
            if (r.use_given) begin
                model_heading = r.given;
            end else begin
                dyaw = (om * dt * 64'sd10937044) >>> 16;
                model_heading = model_heading + dyaw[31:0];
            end
            cordic_sincos(model_heading, c, s);
            model_x = sat32(model_x + ((dx * c - dy * s) >>> 30));
            model_y = sat32(model_y + ((dx * s + dy * c) >>> 30));
        end
        p.vx = vx[15:0];
        p.vy = vy[15:0];
        p.om = om[23:0];
        p.px = model_x[31:0];
        p.py = model_y[31:0];
        p.hd = model_heading;
    endtask

    function automatic logic [15:0] rand_speed();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom());
        endcase
    endfunction

    // Half the random requests use short intervals and half long ones;
    // a few use given headings or clears.
    function automatic odo_req_t rand_req();
        odo_req_t r;
        r.fl = rand_speed();
        r.fr = rand_speed();
        r.rl = rand_speed();
        r.rr = rand_speed();
        case ($urandom_range(0, 3))
            0:       r.dt = 16'($urandom());
            1:       r.dt = 16'hFFFF;
            default: r.dt = 16'($urandom_range(0, 50));
        endcase
        r.use_given = ($urandom_range(0, 4) == 0);
        r.given = $urandom();
        r.clr = ($urandom_range(0, 19) == 0);
        return r;
    endfunction

    function automatic odo_req_t make_req(input logic [15:0] fl, fr, rl, rr, dt,
                                          input logic ug, input logic [31:0] g,
                                          input logic clr);
        odo_req_t r;
        r.fl = fl;
        r.fr = fr;
        r.rl = rl;
        r.rr = rr;
        r.dt = dt;
        r.use_given = ug;
        r.given = g;
        r.clr = clr;
        return r;
    endfunction

    // Write the register while the block is idle and mirror it in the model.
    task automatic write_recip(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model_recip = v;
    endtask

    // Queue a request and its prediction together, so the predictor runs in
    // the same order the driver offers requests.
    task automatic queue_req(input odo_req_t r);
        pose_rpt_t p;
        predict_pose(r, p);
        pending_reqs.push_back(r);
        expected_rpts.push_back(p);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || offering || expected_rpts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_HALF) i_clk = ~i_clk;

    // Driver: offers the oldest pending request, idling at random between
    // requests. Inputs change on the falling edge only.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            offering <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready_seen) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                odo_req_t r;
                r = pending_reqs.pop_front();
                s_axis_tdata <= {r.given, r.dt, r.rr, r.rl, r.fr, r.fl};
                s_axis_tuser <= {r.clr, r.use_given};
                s_axis_tvalid <= 1'b1;
                offering <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
                offering <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_request && hold_left == 0) begin
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_left == 1 && !hold_request) hold_left <= 0;
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each delivered report with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_rpts.size() == 0) begin
                $error("report arrived with no request outstanding");
                fail_count++;
            end else begin
                pose_rpt_t e;
                e = expected_rpts.pop_front();
                report_count++;
                if (m_axis_tdata[15:0] !== e.vx) begin
                    $error("body_vx expected %h got %h", e.vx, m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (m_axis_tdata[31:16] !== e.vy) begin
                    $error("body_vy expected %h got %h", e.vy, m_axis_tdata[31:16]);
                    fail_count++;
                end
                if (m_axis_tdata[55:32] !== e.om) begin
                    $error("body_omega expected %h got %h", e.om, m_axis_tdata[55:32]);
                    fail_count++;
                end
                if (m_axis_tdata[87:56] !== e.px) begin
                    $error("pose_x expected %h got %h", e.px, m_axis_tdata[87:56]);
                    fail_count++;
                end
                if (m_axis_tdata[119:88] !== e.py) begin
                    $error("pose_y expected %h got %h", e.py, m_axis_tdata[119:88]);
                    fail_count++;
                end
                if (m_axis_tdata[151:120] !== e.hd) begin
                    $error("pose_heading expected %h got %h", e.hd, m_axis_tdata[151:120]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    logic [15:0] recip_settings [4] = '{16'd0, 16'hFFFF, 16'd300, 16'd37};

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tready_seen = 1'b0;
        hold_request = 1'b0;
        fail_count = 0;
        report_count = 0;
        cycle_count = 0;
        offering = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 56;
        model_recip = 16'd256;
        model_x = '0;
        model_y = '0;
        model_heading = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset value of the register: extremes of the
        // speeds and the interval, a given heading in each quadrant, and a
        // clear that overrides a given heading.
        queue_req(make_req(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                           1'b0, 32'd0, 1'b0));
        queue_req(make_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                           1'b0, 32'd0, 1'b0));
        queue_req(make_req(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF,
                           1'b0, 32'd0, 1'b0));
        queue_req(make_req(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF,
                           1'b0, 32'd0, 1'b0));
        queue_req(make_req(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd1000,
                           1'b0, 32'd0, 1'b0));
        queue_req(make_req(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF,
                           1'b1, 32'h40000000, 1'b0));
        queue_req(make_req(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'd20,
                           1'b1, 32'h80000000, 1'b0));
        queue_req(make_req(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'd20,
                           1'b1, 32'hC0000000, 1'b0));
        queue_req(make_req(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'd1,
                           1'b1, 32'hFFFFFFFF, 1'b0));
        queue_req(make_req(16'h1234, 16'h4321, 16'hABCD, 16'h5555, 16'd10,
                           1'b1, 32'h12345678, 1'b1));
        for (int i = 0; i < 6; i++)
            queue_req(make_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                               1'b0, 32'd0, 1'b0));
        queue_req(make_req(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0,
                           1'b0, 32'd0, 1'b1));
        wait_idle();

        // Random part in four register settings, with the idle pattern moving
        // from receiver-heavy to sender-heavy to none.
        for (int ph = 0; ph < 4; ph++) begin
            write_recip(recip_settings[ph]);
            send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 56 : 0;
            recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 37 : 0;
            for (int i = 0; i < N_RANDOM / 4; i++)
                queue_req(rand_req());
            if (ph == 2) begin
                // Hold the receiver off while the sender keeps offering; the
                // request spans a full falling edge so the receiver sees it.
                hold_request = 1'b1;
                repeat (2) @(posedge i_clk);
                hold_request = 1'b0;
            end
            wait_idle();
        end

        $display("Covered %0d reports over five register settings, given and integrated",
                 report_count);
        $display("headings, clears, saturation, and sender and receiver back-pressure.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
